// File: rtl/ttl_pkg.sv
// Package for the thermistor table linearizer: payload types, constants and the breakpoint ROM.
// It has no dependencies and is imported by every module of the block.
package ttl_pkg;
   localparam int TABLE_POINTS = 80;
   localparam int ADC_BITS = 12;
   localparam int IDX_BITS = $clog2(TABLE_POINTS);
   localparam logic [3:0] TYPE_RAW = 4'd1;
   localparam logic [3:0] TYPE_THERM = 4'd2;

   typedef struct packed {
      logic [2:0] channel;
      logic [3:0] input_type;
      logic [11:0] sample_code;
   } req_type;

   typedef struct packed {
      logic [2:0] channel_echo;
      logic [15:0] value_q4;
      logic clamped;
   } rsp_type;

   function automatic logic [ADC_BITS-1:0] bp(input logic [IDX_BITS-1:0] i);
      logic [ADC_BITS-1:0] r;
      case (i)
         7'd0: r = 12'd3654; 7'd1: r = 12'd3629; 7'd2: r = 12'd3602; 7'd3: r = 12'd3574;
         7'd4: r = 12'd3546; 7'd5: r = 12'd3516; 7'd6: r = 12'd3485; 7'd7: r = 12'd3452;
         7'd8: r = 12'd3419; 7'd9: r = 12'd3385; 7'd10: r = 12'd3350; 7'd11: r = 12'd3313;
         7'd12: r = 12'd3276; 7'd13: r = 12'd3237; 7'd14: r = 12'd3197; 7'd15: r = 12'd3157;
         7'd16: r = 12'd3114; 7'd17: r = 12'd3072; 7'd18: r = 12'd3028; 7'd19: r = 12'd2984;
         7'd20: r = 12'd2939; 7'd21: r = 12'd2893; 7'd22: r = 12'd2846; 7'd23: r = 12'd2799;
         7'd24: r = 12'd2751; 7'd25: r = 12'd2702; 7'd26: r = 12'd2653; 7'd27: r = 12'd2603;
         7'd28: r = 12'd2553; 7'd29: r = 12'd2503; 7'd30: r = 12'd2453; 7'd31: r = 12'd2402;
         7'd32: r = 12'd2351; 7'd33: r = 12'd2301; 7'd34: r = 12'd2249; 7'd35: r = 12'd2199;
         7'd36: r = 12'd2148; 7'd37: r = 12'd2098; 7'd38: r = 12'd2048; 7'd39: r = 12'd1998;
         7'd40: r = 12'd1949; 7'd41: r = 12'd1900; 7'd42: r = 12'd1852; 7'd43: r = 12'd1803;
         7'd44: r = 12'd1756; 7'd45: r = 12'd1709; 7'd46: r = 12'd1663; 7'd47: r = 12'd1618;
         7'd48: r = 12'd1574; 7'd49: r = 12'd1530; 7'd50: r = 12'd1487; 7'd51: r = 12'd1444;
         7'd52: r = 12'd1403; 7'd53: r = 12'd1362; 7'd54: r = 12'd1322; 7'd55: r = 12'd1283;
         7'd56: r = 12'd1245; 7'd57: r = 12'd1208; 7'd58: r = 12'd1172; 7'd59: r = 12'd1136;
         7'd60: r = 12'd1102; 7'd61: r = 12'd1068; 7'd62: r = 12'd1035; 7'd63: r = 12'd1003;
         7'd64: r = 12'd972; 7'd65: r = 12'd942; 7'd66: r = 12'd912; 7'd67: r = 12'd884;
         7'd68: r = 12'd856; 7'd69: r = 12'd829; 7'd70: r = 12'd803; 7'd71: r = 12'd778;
         7'd72: r = 12'd753; 7'd73: r = 12'd729; 7'd74: r = 12'd706; 7'd75: r = 12'd684;
         7'd76: r = 12'd662; 7'd77: r = 12'd641; 7'd78: r = 12'd620; 7'd79: r = 12'd601;
         default: r = 12'd601;
      endcase
      return r;
   endfunction
endpackage

// File: rtl/ttl_divider.sv
// Pipelined restoring divider for the five-bit interpolation fraction, one quotient bit per stage.
// Depends on ttl_pkg; the side data travels with each transaction through the stages.
module ttl_divider (
   input logic clock,
   input logic reset,
   input logic advance,
   input logic in_valid,
   input logic [ttl_pkg::ADC_BITS-1:0] in_num,
   input logic [ttl_pkg::ADC_BITS-1:0] in_den,
   input ttl_pkg::rsp_type in_side,
   input logic in_div,
   output logic out_valid,
   output ttl_pkg::rsp_type out_side
);
   import ttl_pkg::*;
   localparam int STAGES = 5;
   localparam int RW = ADC_BITS + 1;

   logic [STAGES:0] valid_ff;
   logic [RW-1:0] rem_ff [STAGES+1];
   logic [ADC_BITS-1:0] den_ff [STAGES+1];
   logic [4:0] quo_ff [STAGES+1];
   rsp_type side_ff [STAGES+1];
   logic div_ff [STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (advance) valid_ff <= {valid_ff[STAGES-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= {1'b0, in_num};
         den_ff[0] <= in_den;
         quo_ff[0] <= '0;
         side_ff[0] <= in_side;
         div_ff[0] <= in_div;
         for (int s = 0; s < STAGES; s++) begin
            logic [RW:0] sh;
            sh = {rem_ff[s], 1'b0};
            if (sh >= {2'b00, den_ff[s]}) begin
               rem_ff[s+1] <= RW'(sh - {2'b00, den_ff[s]});
               quo_ff[s+1] <= {quo_ff[s][3:0], 1'b1};
            end else begin
               rem_ff[s+1] <= RW'(sh);
               quo_ff[s+1] <= {quo_ff[s][3:0], 1'b0};
            end
            den_ff[s+1] <= den_ff[s];
            side_ff[s+1] <= side_ff[s];
            div_ff[s+1] <= div_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[STAGES];
   always_comb begin
      out_side = side_ff[STAGES];
      if (div_ff[STAGES])
         out_side.value_q4 = side_ff[STAGES].value_q4 + {11'd0, quo_ff[STAGES]};
   end
endmodule

// File: rtl/thermistor_table_linearizer.sv
// Top level of the thermistor table linearizer: compare, encode, prepare and divide stages.
// Depends on ttl_pkg and ttl_divider.
//
//   Channel   Direction  Payload    Handshake
//   req_      in         req_type   req_valid / req_stall
//   rsp_      out        rsp_type   rsp_valid / rsp_stall
//
// One transaction enters per cycle while the result side is not stalled. The path runs
// through the compare and encode stages, the register that takes the prepared operands
// and the five stages of the fraction divider.
// Reset clears only the valid bits. A stall on a valid result freezes the whole
// pipeline, and req_stall follows that stall so nothing is lost or repeated.
module thermistor_table_linearizer (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input ttl_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output ttl_pkg::rsp_type rsp_data
);
   import ttl_pkg::*;

   logic advance;
   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   logic [ADC_BITS-1:0] cnt;
   assign cnt = req_data.sample_code[ADC_BITS-1:0];

   logic s1_valid_ff;
   req_type s1_req_ff;
   logic [TABLE_POINTS-1:0] s1_ge_ff;
   logic [TABLE_POINTS-1:0] s1_ge_in;

   always_comb begin
      for (int i = 0; i < TABLE_POINTS; i++)
         s1_ge_in[i] = bp(IDX_BITS'(i)) >= cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (advance) s1_valid_ff <= req_valid;
      if (advance) begin
         s1_req_ff <= req_data;
         s1_ge_ff <= s1_ge_in;
      end
   end

   // The breakpoints descend, so the ge vector is a run of ones; its length picks the interval.
   logic [TABLE_POINTS:0] ge_ext;
   logic [IDX_BITS:0] ones_in;
   always_comb begin
      ge_ext = {1'b0, s1_ge_ff};
      ones_in = '0;
      for (int i = 0; i < TABLE_POINTS; i++)
         if (ge_ext[i] && !ge_ext[i+1])
            ones_in = ones_in | (IDX_BITS+1)'(i + 1);
   end

   logic s2_valid_ff;
   req_type s2_req_ff;
   logic [IDX_BITS:0] s2_ones_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (advance) s2_valid_ff <= s1_valid_ff;
      if (advance) begin
         s2_req_ff <= s1_req_ff;
         s2_ones_ff <= ones_in;
      end
   end

   logic [ADC_BITS-1:0] c2;
   logic [IDX_BITS-1:0] idx;
   logic [ADC_BITS-1:0] hi, lo;
   rsp_type side_in;
   logic div_in;
   logic [ADC_BITS-1:0] num_in, den_in;
   logic [ADC_BITS+3:0] raw_q4;

   always_comb begin
      c2 = s2_req_ff.sample_code[ADC_BITS-1:0];
      if (s2_ones_ff >= (IDX_BITS+1)'(TABLE_POINTS))
         idx = IDX_BITS'(TABLE_POINTS - 2);
      else
         idx = IDX_BITS'(s2_ones_ff - 1'b1);
      hi = bp(idx);
      lo = bp(IDX_BITS'(idx + 1'b1));
      raw_q4 = {c2, 4'd0};
      side_in.channel_echo = s2_req_ff.channel;
      side_in.value_q4 = '0;
      side_in.clamped = 1'b0;
      div_in = 1'b0;
      num_in = '0;
      den_in = 12'd1;
      case (s2_req_ff.input_type)
         TYPE_RAW: begin
            side_in.value_q4 = raw_q4;
         end
         TYPE_THERM: begin
            if (s2_ones_ff == '0) begin
               side_in.value_q4 = 16'd16;
               side_in.clamped = 1'b1;
            end else if (s2_ones_ff >= (IDX_BITS+1)'(TABLE_POINTS)) begin
               side_in.value_q4 = 16'(16 * (1 + 2 * (TABLE_POINTS - 1)));
               side_in.clamped = c2 < bp(IDX_BITS'(TABLE_POINTS - 1));
            end else begin
               side_in.value_q4 = {4'd0, idx, 5'd0} + 16'd16;
               if (hi != lo) begin
                  div_in = 1'b1;
                  num_in = hi - c2;
                  den_in = hi - lo;
               end
            end
         end
         default: ;
      endcase
   end

   ttl_divider u_div (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .in_valid(s2_valid_ff),
      .in_num(num_in),
      .in_den(den_in),
      .in_side(side_in),
      .in_div(div_in),
      .out_valid(rsp_valid),
      .out_side(rsp_data)
   );
endmodule
